FILE: design/grid_max_path_dp_unit_assert.svh
// Assertion macros shared by the grid path unit RTL.
`ifndef GRID_MAX_PATH_DP_UNIT_ASSERT_SVH
`define GRID_MAX_PATH_DP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked assertion on clk_i, disabled while rst_ni is low.
`define GMP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("grid path unit: assertion failed");
// Clocked assertion with a caller-supplied message.
`define GMP_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define GMP_ASSERT(label, prop)
`define GMP_ASSERT_MSG(label, prop, msg)
`endif
`endif

FILE: design/gmp_pkg.sv
// Package with the fixed field widths of the grid path unit.
`default_nettype none
package gmp_pkg;
  localparam int unsigned ROW_COUNT_W = 7;
  localparam int unsigned GOLD_W      = 8;
  localparam int unsigned TOTAL_W     = 24;
  localparam logic [TOTAL_W-1:0] TOTAL_CEIL = {TOTAL_W{1'b1}};
endpackage
`default_nettype wire

FILE: design/grid_max_path_dp_unit.sv
// Streaming maximum gold path unit over a grid delivered column by column.
//
//   channel  direction  payload                 handshake
//   in       input      gold_i, end_of_grid_i   in_valid_i / in_ready_o
//   out      output     best_total_o, saturated_o  out_valid_o / out_ready_i
//   cfg      input      row_count_i             cfg_valid_i / cfg_ready_o
//
// One cell is taken in every cycle. The column sums live in a two-read,
// one-write synchronous memory; both neighbor entries for the next cell are
// read in the cycle before it, and a write to an entry being read is
// forwarded. The result sits in an output register, so cells keep flowing
// while a result waits; only a cell arriving while that register is full
// and not being drained is held off, and so is a cell offered together with
// a register write. Reset takes effect at once and needs no clearing pass,
// since no sum is used before it has been written.
`default_nettype none
`include "grid_max_path_dp_unit_assert.svh"
module grid_max_path_dp_unit #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned SUM_BITS = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [gmp_pkg::GOLD_W-1:0]        gold_i,
  input  wire logic                              end_of_grid_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [gmp_pkg::TOTAL_W-1:0]            best_total_o,
  output logic                                   saturated_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [gmp_pkg::ROW_COUNT_W-1:0]   row_count_i
);
  import gmp_pkg::*;

  localparam int unsigned ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int unsigned CMP_W  = (CNT_W > ROW_COUNT_W) ? CNT_W : ROW_COUNT_W;
  localparam int unsigned EXT_W  = (SUM_BITS > TOTAL_W) ? SUM_BITS : TOTAL_W;

  // Grid state.
  logic [ADDR_W-1:0]   pos_q, pos_d;
  logic                first_q, first_d;
  logic [SUM_BITS-1:0] held_q, held_d;
  logic [SUM_BITS-1:0] best_q, best_d;
  logic                ovf_q, ovf_d;
  logic [CNT_W-1:0]    rows_q, rows_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                sat_q, sat_d;

  // Memory ports and forwarding.
  logic [SUM_BITS-1:0] col_mem [MAX_ROWS];
  logic [ADDR_W-1:0]   rd_same_addr, rd_lower_addr;
  logic [SUM_BITS-1:0] rd_same_q, rd_lower_q;
  logic                fwd_same_q, fwd_same_d, fwd_lower_q, fwd_lower_d;
  logic [SUM_BITS-1:0] fwd_data_q;
  logic                wr_en;

  logic                in_fire, cfg_fire, last_row;
  logic [CNT_W-1:0]    pos_inc;
  logic [SUM_BITS-1:0] same_raw, lower_raw, upper_v, same_v, lower_v, best_prev;
  logic [SUM_BITS:0]   sum_wide;
  logic [SUM_BITS-1:0] sum;
  logic                sum_ovf;
  logic [SUM_BITS-1:0] best_new;
  logic                ovf_new;
  logic [EXT_W-1:0]    best_ext;
  logic [CMP_W-1:0]    cfg_ext;

  assign cfg_ready_o = 1'b1;
  // A cell may enter whenever the output register is free or being drained.
  // A register write offered in the same cycle goes first, so the cell waits.
  assign in_ready_o  = (!out_valid_q || out_ready_i) && !cfg_valid_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign pos_inc  = CNT_W'(pos_q) + CNT_W'(1);
  assign last_row = (pos_inc == rows_q);

  // Neighbor sums from the previous column. The upper one was captured from
  // the same-row read of the cell before, before that entry was overwritten.
  always_comb begin
    same_raw  = fwd_same_q  ? fwd_data_q : rd_same_q;
    lower_raw = fwd_lower_q ? fwd_data_q : rd_lower_q;
    upper_v   = (!first_q && (pos_q != '0)) ? held_q : '0;
    same_v    = first_q ? '0 : same_raw;
    lower_v   = (!first_q && !last_row) ? lower_raw : '0;
    best_prev = upper_v;
    if (same_v > best_prev) begin
      best_prev = same_v;
    end
    if (lower_v > best_prev) begin
      best_prev = lower_v;
    end
    sum_wide = {1'b0, best_prev} + (SUM_BITS + 1)'(gold_i);
    sum_ovf  = sum_wide[SUM_BITS];
    sum      = sum_ovf ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
    best_new = (sum > best_q) ? sum : best_q;
    ovf_new  = ovf_q || sum_ovf;
    best_ext = EXT_W'(best_new);
  end

  // Next state of the grid walk and of the output register.
  always_comb begin
    pos_d       = pos_q;
    first_d     = first_q;
    held_d      = held_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    rows_d      = rows_q;
    out_valid_d = out_valid_q;
    total_d     = total_q;
    sat_d       = sat_q;
    cfg_ext     = CMP_W'(row_count_i);
    wr_en       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_fire) begin
      // A new row count abandons any grid in progress.
      if (cfg_ext == '0) begin
        rows_d = CNT_W'(1);
      end else if (cfg_ext > CMP_W'(MAX_ROWS)) begin
        rows_d = CNT_W'(MAX_ROWS);
      end else begin
        rows_d = cfg_ext[CNT_W-1:0];
      end
      pos_d   = '0;
      first_d = 1'b1;
      held_d  = '0;
      best_d  = '0;
      ovf_d   = 1'b0;
    end else if (in_fire) begin
      wr_en  = 1'b1;
      held_d = same_raw;
      if (end_of_grid_i) begin
        out_valid_d = 1'b1;
        if (best_ext > EXT_W'(TOTAL_CEIL)) begin
          total_d = TOTAL_CEIL;
          sat_d   = 1'b1;
        end else begin
          total_d = best_ext[TOTAL_W-1:0];
          sat_d   = ovf_new;
        end
        pos_d   = '0;
        first_d = 1'b1;
        held_d  = '0;
        best_d  = '0;
        ovf_d   = 1'b0;
      end else begin
        pos_d   = last_row ? '0 : pos_inc[ADDR_W-1:0];
        first_d = first_q && !last_row;
        best_d  = best_new;
        ovf_d   = ovf_new;
      end
    end
  end

  // The memory is always read at the entries the next cell will need; a
  // write landing on one of them in the same cycle is forwarded next cycle.
  assign rd_same_addr  = pos_d;
  assign rd_lower_addr = pos_d + ADDR_W'(1);
  assign fwd_same_d    = wr_en && (pos_q == rd_same_addr);
  assign fwd_lower_d   = wr_en && (pos_q == rd_lower_addr);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      col_mem[pos_q] <= sum;
    end
    rd_same_q  <= col_mem[rd_same_addr];
    rd_lower_q <= col_mem[rd_lower_addr];
    fwd_data_q <= sum;
  end

  always_ff @(posedge clk_i) begin
    held_q  <= held_d;
    total_q <= total_d;
    sat_q   <= sat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      first_q     <= 1'b1;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      rows_q      <= CNT_W'(1);
      out_valid_q <= 1'b0;
      fwd_same_q  <= 1'b0;
      fwd_lower_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      first_q     <= first_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      rows_q      <= rows_d;
      out_valid_q <= out_valid_d;
      fwd_same_q  <= fwd_same_d;
      fwd_lower_q <= fwd_lower_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_total_o = total_q;
  assign saturated_o  = sat_q;

  // The row position always stays inside the configured column.
  `GMP_ASSERT(a_pos_in_range, (CNT_W'(pos_q) < rows_q))
  // A cell flagged as last always leaves a result in the output register.
  `GMP_ASSERT(a_last_gives_result, (in_fire && end_of_grid_i && !cfg_fire) |=> out_valid_q)
  // Finishing a column that does not end the grid leaves the first column.
  `GMP_ASSERT_MSG(a_column_wrap,
    (in_fire && !end_of_grid_i && !cfg_fire && last_row) |=> !first_q,
    "grid path unit: first column flag not cleared at column end")
  // Forwarding is only ever armed by a memory write in the cycle before.
  `GMP_ASSERT(a_fwd_after_write, (fwd_same_q || fwd_lower_q) |-> $past(wr_en))
endmodule
`default_nettype wire
